FILE: design/rse_pkg.sv
// Shared types, opcode codes and helper functions for the RISC subset execute unit.
package rse_pkg;

    localparam int unsigned MEM_WORDS_DEF = 4096;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_OP   = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    // Request kinds
    localparam logic KIND_PRELOAD = 1'b0;
    localparam logic KIND_EXECUTE = 1'b1;

    typedef enum logic [5:0] {
        OP_HALT  = 6'h00,
        OP_LD_RR = 6'h04,
        OP_LD_RI = 6'h05,
        OP_ST    = 6'h07,
        OP_BNE   = 6'h14,
        OP_BNE_L = 6'h15,
        OP_BEQ   = 6'h16,
        OP_BEQ_L = 6'h17,
        OP_BR    = 6'h1a,
        OP_BCS   = 6'h1c,
        OP_BCC   = 6'h1e,
        OP_ADDS  = 6'h24,
        OP_ADDI  = 6'h25,
        OP_SUBS  = 6'h26,
        OP_SUBI  = 6'h27,
        OP_SHL   = 6'h28,
        OP_SHLI  = 6'h29,
        OP_SHR   = 6'h2a,
        OP_SHRI  = 6'h2b,
        OP_SRA   = 6'h2e,
        OP_SRAI  = 6'h2f
    } op_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] instr_word;
        logic [31:0] instr_addr;
        logic [11:0] preload_index;
        logic [31:0] preload_data;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic        halted;
        logic        branch_seen;
        logic        branch_taken;
        logic        mem_read;
        logic        mem_write;
        logic        reg_write;
        logic [4:0]  wb_dest;
        logic [31:0] reg_value;
        logic        cc_flag;
    } out_t;

    // Execute stage result handed to the pipeline control
    typedef struct packed {
        out_t        res;
        logic [29:0] mem_word;
    } exe_t;

    function automatic logic [31:0] sext16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sext26(input logic [25:0] x);
        return {{6{x[25]}}, x};
    endfunction

endpackage

FILE: design/rse_regfile.sv
// Register file memory: two registered read ports, one write port, per-entry valid bits.
module rse_regfile import rse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        rd_en,
    input  logic [4:0]  rd_addr_a,
    input  logic [4:0]  rd_addr_b,
    output logic [31:0] rd_data_a,
    output logic [31:0] rd_data_b,
    input  logic        wr_en,
    input  logic [4:0]  wr_addr,
    input  logic [31:0] wr_data
);

    logic [31:0] mem [32];
    logic [31:0] vld_reg;
    logic [31:0] data_a_reg;
    logic [31:0] data_b_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic        hit_a;
    logic        hit_b;

    assign hit_a = wr_en && (wr_addr == rd_addr_a);
    assign hit_b = wr_en && (wr_addr == rd_addr_b);

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_a_reg <= hit_a || vld_reg[rd_addr_a];
                vld_b_reg <= hit_b || vld_reg[rd_addr_b];
            end
        end
    end

    // Write, and read with write-first bypass on the same address
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_a_reg <= hit_a ? wr_data : mem[rd_addr_a];
            data_b_reg <= hit_b ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = vld_a_reg ? data_a_reg : 32'd0;
    assign rd_data_b = vld_b_reg ? data_b_reg : 32'd0;

endmodule

FILE: design/rse_dmem.sv
// Data memory: single port, one read or write per cycle, registered read data.
module rse_dmem import rse_pkg::*; #(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
    parameter int unsigned AW        = $clog2(MEM_WORDS)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wr_data,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rd_data_reg;

    // Write or read the addressed word; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/rse_exec.sv
// Execute logic: decode, ALU, shifter, branch target and data address check.
module rse_exec import rse_pkg::*; #(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic [31:0] instr_word,
    input  logic [31:0] instr_addr,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    input  logic        cc_in,
    output exe_t        exe
);

    op_t         op;
    logic [4:0]  d;
    logic [4:0]  s1;
    logic [15:0] imm;
    logic [15:0] off;
    logic [31:0] imm_s;
    logic [31:0] off_s;
    logic [31:0] long_s;
    logic [31:0] pc4;
    logic [32:0] sum_rr;
    logic [32:0] sum_ri;
    logic [31:0] sh_amt;
    logic        sh_big;
    logic [31:0] shl_res;
    logic [31:0] shr_res;
    logic [31:0] sra_res;
    logic [31:0] tgt16;
    logic [31:0] tgt26;
    logic [31:0] ea;
    logic        in_range;
    logic        cond;
    logic        wr;
    logic [31:0] res;

    // Field extraction and shared datapath
    assign op     = op_t'(instr_word[31:26]);
    assign d      = instr_word[20:16];
    assign s1     = instr_word[15:11];
    assign imm    = instr_word[15:0];
    assign off    = {instr_word[20:16], instr_word[10:0]};
    assign imm_s  = sext16(imm);
    assign off_s  = sext16(off);
    assign long_s = sext26(instr_word[25:0]);
    assign pc4    = instr_addr + 32'd4;
    assign sum_rr = {op_a[31], op_a} + {op_b[31], op_b};
    assign sum_ri = {op_b[31], op_b} + {imm_s[31], imm_s};
    assign tgt16  = pc4 + {off_s[29:0], 2'b00};
    assign tgt26  = pc4 + {long_s[29:0], 2'b00};

    // Shifter: register or immediate amount, saturating at 32
    always_comb begin
        if (op == OP_SHL || op == OP_SHR || op == OP_SRA) begin
            sh_amt = op_a;
        end else begin
            sh_amt = {16'd0, imm};
        end
    end
    assign sh_big  = |sh_amt[31:5];
    assign shl_res = sh_big ? 32'd0 : (op_b << sh_amt[4:0]);
    assign shr_res = sh_big ? 32'd0 : (op_b >> sh_amt[4:0]);
    assign sra_res = sh_big ? {32{op_b[31]}} : $unsigned($signed(op_b) >>> sh_amt[4:0]);

    // Effective address: register pair, register plus immediate, or register plus offset
    assign ea = (op == OP_LD_RR) ? (op_a + op_b) :
                ((op == OP_LD_RI) ? (op_b + imm_s) : (op_b + off_s));

    assign in_range = {2'b00, ea[31:2]} < 32'(MEM_WORDS);

    // Decode and execute
    always_comb begin
        exe          = '0;
        exe.res.next_pc = pc4;
        exe.res.cc_flag = cc_in;
        cond = 1'b0;
        wr   = 1'b0;
        res  = 32'd0;
        unique case (op) inside
            OP_HALT:  exe.res.halted = 1'b1;
            OP_LD_RR: exe.res.mem_read = 1'b1;
            OP_LD_RI: exe.res.mem_read = 1'b1;
            OP_ST:    exe.res.mem_write = 1'b1;
            OP_BNE:   begin exe.res.branch_seen = 1'b1; cond = op_a != op_b; end
            OP_BNE_L: begin exe.res.branch_seen = 1'b1; cond = {27'd0, s1} != op_b; end
            OP_BEQ:   begin exe.res.branch_seen = 1'b1; cond = op_a == op_b; end
            OP_BEQ_L: begin exe.res.branch_seen = 1'b1; cond = {27'd0, s1} == op_b; end
            OP_BR:    begin exe.res.branch_seen = 1'b1; cond = 1'b1; end
            OP_BCS:   begin exe.res.branch_seen = 1'b1; cond = cc_in; end
            OP_BCC:   begin exe.res.branch_seen = 1'b1; cond = !cc_in; end
            OP_ADDS: begin
                res = sum_rr[31:0]; wr = 1'b1; exe.res.cc_flag = sum_rr[32];
            end
            OP_ADDI: begin
                res = sum_ri[31:0]; wr = 1'b1; exe.res.cc_flag = sum_ri[32];
            end
            OP_SUBS: begin
                res = op_a - op_b; wr = 1'b1;
                exe.res.cc_flag = $signed(op_b) > $signed(op_a);
            end
            OP_SUBI: begin
                res = {16'd0, imm} - op_b; wr = 1'b1;
                exe.res.cc_flag = $signed({op_b[31], op_b}) > $signed({17'd0, imm});
            end
            OP_SHL, OP_SHLI: begin res = shl_res; wr = 1'b1; end
            OP_SHR, OP_SHRI: begin res = shr_res; wr = 1'b1; end
            OP_SRA, OP_SRAI: begin res = sra_res; wr = 1'b1; end
            default: exe.res.status = ST_BAD_OP;
        endcase

        // Take the branch: short displacement for compares, long otherwise
        if (exe.res.branch_seen && cond) begin
            exe.res.branch_taken = 1'b1;
            if (op == OP_BR || op == OP_BCS || op == OP_BCC) begin
                exe.res.next_pc = tgt26;
            end else begin
                exe.res.next_pc = tgt16;
            end
        end

        // Drop memory access outside the data memory
        if (exe.res.mem_read || exe.res.mem_write) begin
            if (!in_range) begin
                exe.res.status    = ST_BAD_ADDR;
                exe.res.mem_read  = 1'b0;
                exe.res.mem_write = 1'b0;
            end else if (exe.res.mem_read) begin
                wr = 1'b1;
            end
        end

        // Discard writes to r0; load data is filled in later
        if (wr && d != 5'd0) begin
            exe.res.reg_write = 1'b1;
            exe.res.wb_dest   = d;
            exe.res.reg_value = res;
        end
        exe.mem_word = ea[31:2];
    end

endmodule

FILE: design/risc_subset_execute_unit.sv
// Top level: three-step pipeline around the register file and data memory.
// A request passes the execute, writeback and output registers before its result is valid on m_.
// Throughput: one request per cycle while m_ready keeps up; an instruction that reads
// the destination of the load just ahead of it waits for the data memory read.
// Reset (aresetn low, synchronous) empties the pipeline, clears the condition bit
// and marks all registers zero; data memory contents stay undefined until written.
module risc_subset_execute_unit import rse_pkg::*; #(
    parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic          s_accept;
    logic          b_valid_reg, b_valid_next;
    in_t           b_item_reg;
    logic          b_adv;
    logic          b_exec;
    logic          stall;
    logic [4:0]    b_s1;
    logic [4:0]    b_s2;
    logic [31:0]   rf_a;
    logic [31:0]   rf_b;
    logic [31:0]   fwd_a;
    logic [31:0]   fwd_b;
    logic          byp_valid_reg, byp_valid_next;
    logic [4:0]    byp_idx_reg;
    logic [31:0]   byp_val_reg;
    logic          cc_reg, cc_next;
    exe_t          exe;
    out_t          c_in;
    logic          c_valid_reg, c_valid_next;
    out_t          c_reg;
    logic          c_load_reg;
    logic          c_adv;
    out_t          c_final;
    logic          m_valid_reg, m_valid_next;
    out_t          m_data_reg;
    logic          rf_we;
    logic [31:0]   dmem_rdata;
    logic          dmem_re;
    logic          dmem_we;
    logic [AW-1:0] dmem_addr;
    logic [31:0]   dmem_wdata;
    logic [31:0]   pre_idx;
    logic          pre_ok;

    // Handshake and stage advance
    assign s_accept = s_valid && s_ready;
    assign b_exec   = b_item_reg.opcode == KIND_EXECUTE;
    assign b_s1     = b_item_reg.instr_word[15:11];
    assign b_s2     = b_item_reg.instr_word[25:21];
    assign c_adv    = c_valid_reg && (!m_valid_reg || m_ready);
    assign stall    = b_valid_reg && b_exec && c_valid_reg && c_load_reg && c_reg.reg_write
                      && (c_reg.wb_dest == b_s1 || c_reg.wb_dest == b_s2);
    assign b_adv    = b_valid_reg && !stall && (!c_valid_reg || c_adv);
    assign s_ready  = !b_valid_reg || b_adv;
    assign rf_we    = c_adv && c_reg.reg_write;

    rse_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (s_data.instr_word[15:11]),
        .rd_addr_b (s_data.instr_word[25:21]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr_en     (rf_we),
        .wr_addr   (c_reg.wb_dest),
        .wr_data   (c_final.reg_value)
    );

    // Forward results not yet seen by the register read
    always_comb begin
        fwd_a = rf_a;
        fwd_b = rf_b;
        if (byp_valid_reg && byp_idx_reg == b_s1) begin
            fwd_a = byp_val_reg;
        end
        if (byp_valid_reg && byp_idx_reg == b_s2) begin
            fwd_b = byp_val_reg;
        end
        if (c_valid_reg && c_reg.reg_write && !c_load_reg && c_reg.wb_dest == b_s1) begin
            fwd_a = c_reg.reg_value;
        end
        if (c_valid_reg && c_reg.reg_write && !c_load_reg && c_reg.wb_dest == b_s2) begin
            fwd_b = c_reg.reg_value;
        end
    end

    rse_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .instr_word (b_item_reg.instr_word),
        .instr_addr (b_item_reg.instr_addr),
        .op_a       (fwd_a),
        .op_b       (fwd_b),
        .cc_in      (cc_reg),
        .exe        (exe)
    );

    // Build the stage result: a preload reports only the condition bit
    always_comb begin
        c_in = '0;
        c_in.cc_flag = cc_reg;
        if (b_exec) begin
            c_in = exe.res;
        end
    end

    // Data memory request, issued as the request leaves the execute step
    assign pre_idx    = {20'd0, b_item_reg.preload_index};
    assign pre_ok     = pre_idx < 32'(MEM_WORDS);
    assign dmem_re    = b_adv && b_exec && exe.res.mem_read;
    assign dmem_we    = b_adv && (b_exec ? exe.res.mem_write : pre_ok);
    assign dmem_addr  = b_exec ? exe.mem_word[AW-1:0] : pre_idx[AW-1:0];
    assign dmem_wdata = b_exec ? fwd_a : b_item_reg.preload_data;

    rse_dmem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_dmem (
        .aclk    (aclk),
        .rd_en   (dmem_re),
        .wr_en   (dmem_we),
        .addr    (dmem_addr),
        .wr_data (dmem_wdata),
        .rd_data (dmem_rdata)
    );

    // Merge load data into the writeback step
    always_comb begin
        c_final = c_reg;
        if (c_load_reg && c_reg.reg_write) begin
            c_final.reg_value = dmem_rdata;
        end
    end

    // Next values of control state
    always_comb begin
        b_valid_next   = s_accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
        c_valid_next   = b_adv ? 1'b1 : (c_adv ? 1'b0 : c_valid_reg);
        m_valid_next   = c_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        cc_next        = (b_adv && b_exec) ? exe.res.cc_flag : cc_reg;
        byp_valid_next = s_accept ? 1'b0 : (rf_we ? 1'b1 : byp_valid_reg);
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            cc_reg        <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            m_valid_reg   <= m_valid_next;
            cc_reg        <= cc_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_item_reg <= s_data;
        end
        if (b_adv) begin
            c_reg      <= c_in;
            c_load_reg <= b_exec && exe.res.mem_read;
        end
        if (c_adv) begin
            m_data_reg <= c_final;
        end
        if (rf_we) begin
            byp_idx_reg <= c_reg.wb_dest;
            byp_val_reg <= c_final.reg_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: design/rse_checker.sv
// Port-level checker for the execute unit, bound to the top level.
module rse_checker import rse_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A register write never targets r0, and no write reports no index or value
    a_wb_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.reg_write ? (m_data.wb_dest != 5'd0)
                     : (m_data.wb_dest == 5'd0 && m_data.reg_value == 32'd0)))
        else $error("bad writeback fields");

    // A failed request changes no state
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK
        |-> !m_data.reg_write && !m_data.mem_read && !m_data.mem_write)
        else $error("error result with side effects");

    // Taken implies a branch; halt does nothing else
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.branch_taken || m_data.branch_seen)
                    && (!m_data.halted || (!m_data.reg_write && !m_data.branch_seen)))
        else $error("inconsistent result flags");

endmodule

bind risc_subset_execute_unit rse_checker u_rse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/risc_subset_execute_unit_tb.sv
// Self-checking testbench for the RISC subset execute unit: directed and random requests.
module risc_subset_execute_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rse_pkg::*;

    localparam int unsigned MEM_WORDS   = MEM_WORDS_DEF;
    localparam int          NUM_ITEMS   = 1650;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES = 10;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [5:0]  OP_UNUSED   = 6'h3f;

    // Architectural state mirror plus the queue of results still owed by the block
    class isa_scoreboard;
        logic [31:0] gpr [32];
        logic [31:0] dmem [MEM_WORDS];
        bit          dmem_set [MEM_WORDS];
        bit          cond_bit;
        out_t        awaited [$];
        int          errors;
        int          results_checked;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem_set[i]) dmem_set[i] = 1'b0;
            cond_bit        = 1'b0;
            errors          = 0;
            results_checked = 0;
        endfunction

        // Byte address of a load or store under the current register contents
        function logic [31:0] data_addr(logic [31:0] w);
            logic [15:0] off;
            off = {w[20:16], w[10:0]};
            case (w[31:26])
                OP_LD_RR: return gpr[w[15:11]] + gpr[w[25:21]];
                OP_LD_RI: return gpr[w[25:21]] + {{16{w[15]}}, w[15:0]};
                default:  return gpr[w[25:21]] + {{16{off[15]}}, off};
            endcase
        endfunction

        // Word a load would read, or -1 when it reads nothing in range
        function int load_word(logic [31:0] w);
            logic [31:0] wd;
            if (w[31:26] != OP_LD_RR && w[31:26] != OP_LD_RI) return -1;
            wd = data_addr(w) >> 2;
            return (wd < MEM_WORDS) ? int'(wd) : -1;
        endfunction

        // Execute one accepted request on the mirror and queue its result
        function void note_request(in_t req);
            out_t        r;
            logic [31:0] w, a, b, res, disp, word, amt;
            logic [31:0] sx_imm, sx_off, sx_long;
            logic [15:0] imm, off;
            logic [4:0]  d, s1;
            bit          cond, wr;
            r = '0;
            if (req.opcode == KIND_PRELOAD) begin
                if (req.preload_index < MEM_WORDS) begin
                    dmem[req.preload_index]     = req.preload_data;
                    dmem_set[req.preload_index] = 1'b1;
                end
            end else begin
                w       = req.instr_word;
                d       = w[20:16];
                s1      = w[15:11];
                imm     = w[15:0];
                off     = {w[20:16], w[10:0]};
                sx_imm  = {{16{imm[15]}}, imm};
                sx_off  = {{16{off[15]}}, off};
                sx_long = {{6{w[25]}}, w[25:0]};
                a       = gpr[s1];
                b       = gpr[w[25:21]];
                amt     = w[26] ? {16'd0, imm} : a;
                res     = '0;
                disp    = '0;
                cond    = 1'b0;
                wr      = 1'b0;
                r.next_pc = req.instr_addr + 32'd4;
                case (w[31:26]) inside
                    OP_HALT:  r.halted = 1'b1;
                    OP_LD_RR, OP_LD_RI: r.mem_read = 1'b1;
                    OP_ST:    r.mem_write = 1'b1;
                    OP_BNE:   begin r.branch_seen = 1'b1; cond = (a != b); disp = sx_off; end
                    OP_BNE_L: begin
                        r.branch_seen = 1'b1; cond = ({27'd0, s1} != b); disp = sx_off;
                    end
                    OP_BEQ:   begin r.branch_seen = 1'b1; cond = (a == b); disp = sx_off; end
                    OP_BEQ_L: begin
                        r.branch_seen = 1'b1; cond = ({27'd0, s1} == b); disp = sx_off;
                    end
                    OP_BR:    begin r.branch_seen = 1'b1; cond = 1'b1; disp = sx_long; end
                    OP_BCS:   begin r.branch_seen = 1'b1; cond = cond_bit; disp = sx_long; end
                    OP_BCC:   begin r.branch_seen = 1'b1; cond = !cond_bit; disp = sx_long; end
                    OP_ADDS: begin
                        res = a + b; wr = 1'b1;
                        cond_bit = (longint'($signed(a)) + longint'($signed(b))) < 0;
                    end
                    OP_ADDI: begin
                        res = b + sx_imm; wr = 1'b1;
                        cond_bit = (longint'($signed(b)) + longint'($signed(sx_imm))) < 0;
                    end
                    OP_SUBS: begin
                        res = a - b; wr = 1'b1;
                        cond_bit = $signed(b) > $signed(a);
                    end
                    OP_SUBI: begin
                        res = {16'd0, imm} - b; wr = 1'b1;
                        cond_bit = longint'($signed(b)) > longint'(imm);
                    end
                    OP_SHL, OP_SHLI: begin
                        wr = 1'b1;
                        if (amt >= 32) res = '0;
                        else res = b << amt[4:0];
                    end
                    OP_SHR, OP_SHRI: begin
                        wr = 1'b1;
                        if (amt >= 32) res = '0;
                        else res = b >> amt[4:0];
                    end
                    OP_SRA, OP_SRAI: begin
                        wr = 1'b1;
                        if (amt >= 32) res = {32{b[31]}};
                        else res = $signed(b) >>> amt[4:0];
                    end
                    default: r.status = ST_BAD_OP;
                endcase

                if (r.branch_seen && cond) begin
                    r.branch_taken = 1'b1;
                    r.next_pc      = req.instr_addr + (disp << 2) + 32'd4;
                end

                // Memory access: out-of-range words abort the access and the writeback
                if (r.mem_read || r.mem_write) begin
                    word = data_addr(w) >> 2;
                    if (word >= MEM_WORDS) begin
                        r.status    = ST_BAD_ADDR;
                        r.mem_read  = 1'b0;
                        r.mem_write = 1'b0;
                    end else if (r.mem_write) begin
                        dmem[word[11:0]]     = a;
                        dmem_set[word[11:0]] = 1'b1;
                    end else begin
                        res = dmem[word[11:0]];
                        wr  = 1'b1;
                    end
                end

                // Drop writes to r0
                if (wr && d != 5'd0) begin
                    gpr[d]      = res;
                    r.reg_write = 1'b1;
                    r.wb_dest   = d;
                    r.reg_value = res;
                end
            end
            r.cc_flag = cond_bit;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS) $display("ERROR result %0d: %s", results_checked, msg);
            errors++;
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want) report_mismatch($sformatf("%s got %h want %h", field, got, want));
        endtask

        // Compare one delivered result against the oldest pending one
        task check_result(out_t got);
            out_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result with no request pending");
                return;
            end
            want = awaited.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("next_pc", got.next_pc, want.next_pc);
            compare_field("halted", got.halted, want.halted);
            compare_field("branch_seen", got.branch_seen, want.branch_seen);
            compare_field("branch_taken", got.branch_taken, want.branch_taken);
            compare_field("mem_read", got.mem_read, want.mem_read);
            compare_field("mem_write", got.mem_write, want.mem_write);
            compare_field("reg_write", got.reg_write, want.reg_write);
            compare_field("wb_dest", got.wb_dest, want.wb_dest);
            compare_field("reg_value", got.reg_value, want.reg_value);
            compare_field("cc_flag", got.cc_flag, want.cc_flag);
            results_checked++;
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    isa_scoreboard sb;
    int            n_sent;
    bit            hold_off_req;
    bit            calm;

    op_t cmp_ops [4]       = '{OP_BNE, OP_BNE_L, OP_BEQ, OP_BEQ_L};
    op_t long_ops [3]      = '{OP_BR, OP_BCS, OP_BCC};
    op_t reg_arith_ops [2] = '{OP_ADDS, OP_SUBS};
    op_t imm_arith_ops [2] = '{OP_ADDI, OP_SUBI};
    op_t reg_shift_ops [3] = '{OP_SHL, OP_SHR, OP_SRA};
    op_t imm_shift_ops [3] = '{OP_SHLI, OP_SHRI, OP_SRAI};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    risc_subset_execute_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Instruction encoders
    function automatic logic [31:0] enc_imm(logic [5:0] op, logic [4:0] s2, logic [4:0] d,
                                            logic [15:0] imm);
        return {op, s2, d, imm};
    endfunction

    function automatic logic [31:0] enc_reg(logic [5:0] op, logic [4:0] s2, logic [4:0] d,
                                            logic [4:0] s1);
        return {op, s2, d, s1, 11'($urandom())};
    endfunction

    // Stores and compare branches split the 16-bit offset around s1
    function automatic logic [31:0] enc_off(logic [5:0] op, logic [4:0] s2, logic [4:0] s1,
                                            logic [15:0] off);
        return {op, s2, off[15:11], s1, off[10:0]};
    endfunction

    function automatic logic [31:0] enc_long(logic [5:0] op, logic [25:0] disp);
        return {op, disp};
    endfunction

    function automatic logic [4:0] rand_dest();
        return ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    endfunction

    // Idle length: mostly none or short, a few long, none at all in calm stretches
    function automatic int idle_cycles();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(input in_t req);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
        n_sent++;
        calm = ((n_sent / 120) % 5) == 2;
        if (n_sent == 500) hold_off_req = 1'b1;
    endtask

    task automatic send_preload(input logic [11:0] idx, input logic [31:0] val);
        in_t req;
        req.opcode        = KIND_PRELOAD;
        req.instr_word    = $urandom();
        req.instr_addr    = $urandom();
        req.preload_index = idx;
        req.preload_data  = val;
        send_request(req);
    endtask

    task automatic issue_instr(input logic [31:0] w, input logic [31:0] pc);
        in_t req;
        int  word;
        // Fill a word before its first load so no load sees unwritten memory
        word = sb.load_word(w);
        if (word >= 0 && !sb.dmem_set[word]) send_preload(word[11:0], $urandom());
        req.opcode        = KIND_EXECUTE;
        req.instr_word    = w;
        req.instr_addr    = pc;
        req.preload_index = 12'($urandom());
        req.preload_data  = $urandom();
        send_request(req);
    endtask

    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [4:0]  s2, d, s1;
        logic [15:0] imm;
        s2  = 5'($urandom());
        d   = rand_dest();
        s1  = 5'($urandom());
        imm = 16'($urandom());
        if ($urandom_range(0, 3) == 0) imm = 16'($urandom_range(0, 40));
        case ($urandom_range(0, 14))
            0:  w = $urandom();
            1:  w = enc_imm(OP_HALT, s2, d, imm);
            2:  w = enc_reg(OP_LD_RR, s2, d, s1);
            3:  w = enc_imm(OP_LD_RI, 5'd0, d, 16'($urandom_range(0, 16383)));
            4:  w = enc_imm(OP_LD_RI, s2, d, imm);
            5:  w = enc_off(OP_ST, 5'd0, s1, 16'($urandom_range(0, 16383)));
            6:  w = enc_off(OP_ST, s2, s1, imm);
            7:  w = enc_off(cmp_ops[$urandom_range(0, 3)], s2, s1, 16'($urandom()));
            8:  w = enc_long(long_ops[$urandom_range(0, 2)], 26'($urandom()));
            9:  w = enc_reg(reg_arith_ops[$urandom_range(0, 1)], s2, d, s1);
            10: w = enc_imm(imm_arith_ops[$urandom_range(0, 1)], s2, d, imm);
            11: w = enc_reg(reg_shift_ops[$urandom_range(0, 2)], s2, d, s1);
            12: w = enc_imm(imm_shift_ops[$urandom_range(0, 2)], s2, d, imm);
            default: w = enc_imm(OP_ADDI, 5'd0, d, imm);
        endcase
        return w;
    endfunction

    // Short dependent instruction groups that exercise the interesting paths
    task automatic run_sequence();
        logic [4:0]  rb, rx, ry;
        logic [15:0] v;
        int          n;
        rb = 5'($urandom_range(1, 31));
        rx = 5'($urandom_range(1, 31));
        ry = 5'($urandom_range(1, 31));
        case ($urandom_range(0, 3))
            0: begin
                // Point a base register into memory, then load and store around it
                issue_instr(enc_imm(OP_ADDI, 5'd0, rb, 16'($urandom_range(0, 16383))),
                            $urandom());
                n = $urandom_range(1, 4);
                repeat (n) begin
                    v = 16'($urandom_range(0, 127)) - 16'd64;
                    case ($urandom_range(0, 2))
                        0: issue_instr(enc_imm(OP_LD_RI, rb, rand_dest(), v), $urandom());
                        1: issue_instr(enc_off(OP_ST, rb, 5'($urandom()), v), $urandom());
                        default: issue_instr(enc_reg(OP_LD_RR, rb, rand_dest(),
                                                     ($urandom_range(0, 1) == 0) ? 5'd0 : rx),
                                             $urandom());
                    endcase
                end
            end
            1: begin
                // Load a small value, then compare against a literal or a register
                v = 16'($urandom_range(0, 31));
                issue_instr(enc_imm(OP_ADDI, 5'd0, rx, v), $urandom());
                if ($urandom_range(0, 1) == 0) begin
                    issue_instr(enc_off(($urandom_range(0, 1) == 0) ? OP_BNE_L : OP_BEQ_L, rx,
                                        ($urandom_range(0, 1) == 0) ? v[4:0] : 5'($urandom()),
                                        16'($urandom())), $urandom());
                end else begin
                    issue_instr(enc_imm(OP_ADDI, 5'd0, ry,
                                        ($urandom_range(0, 1) == 0) ? v : 16'($urandom())),
                                $urandom());
                    issue_instr(enc_off(($urandom_range(0, 1) == 0) ? OP_BNE : OP_BEQ, rx, ry,
                                        16'($urandom())), $urandom());
                end
            end
            2: begin
                // Set the condition bit, then branch on it
                if ($urandom_range(0, 1) == 0)
                    issue_instr(enc_reg(reg_arith_ops[$urandom_range(0, 1)], 5'($urandom()),
                                        rand_dest(), 5'($urandom())), $urandom());
                else
                    issue_instr(enc_imm(imm_arith_ops[$urandom_range(0, 1)], 5'($urandom()),
                                        rand_dest(), 16'($urandom())), $urandom());
                issue_instr(enc_long(long_ops[$urandom_range(0, 2)], 26'($urandom())),
                            $urandom());
            end
            default: begin
                // Shift by a register amount around the 32 boundary
                issue_instr(enc_imm(OP_ADDI, 5'd0, rx, 16'($urandom_range(0, 40))), $urandom());
                issue_instr(enc_reg(reg_shift_ops[$urandom_range(0, 2)], 5'($urandom()),
                                    rand_dest(), rx), $urandom());
            end
        endcase
    endtask

    // Field extremes, most operations and the corner cases
    task automatic run_directed();
        send_preload(12'h000, 32'h0000_0000);
        send_preload(12'hfff, 32'hffff_ffff);
        issue_instr(enc_imm(OP_LD_RI, 5'd0, 5'd1, 16'h3ffc), 32'h0000_0000);
        issue_instr(enc_imm(OP_LD_RI, 5'd0, 5'd0, 16'h0000), 32'hffff_fffc);
        issue_instr(enc_imm(OP_ADDI, 5'd0, 5'd2, 16'h7fff), 32'h0000_1000);
        issue_instr(enc_imm(OP_ADDI, 5'd0, 5'd3, 16'h8000), 32'h0000_1004);
        issue_instr(enc_imm(OP_ADDI, 5'd0, 5'd4, 16'h0001), 32'h0000_1008);
        issue_instr(enc_imm(OP_SHLI, 5'd4, 5'd5, 16'd31), 32'h0000_100c);
        issue_instr(enc_reg(OP_ADDS, 5'd5, 5'd6, 5'd5), 32'h0000_1010);
        issue_instr(enc_imm(OP_SHRI, 5'd1, 5'd7, 16'd1), 32'h0000_1014);
        issue_instr(enc_reg(OP_ADDS, 5'd7, 5'd8, 5'd7), 32'h0000_1018);
        issue_instr(enc_reg(OP_SUBS, 5'd7, 5'd9, 5'd5), 32'h0000_101c);
        issue_instr(enc_imm(OP_SUBI, 5'd1, 5'd10, 16'hffff), 32'h0000_1020);
        issue_instr(enc_imm(OP_SRAI, 5'd5, 5'd11, 16'd40), 32'h0000_1024);
        issue_instr(enc_reg(OP_SRA, 5'd5, 5'd12, 5'd2), 32'h0000_1028);
        issue_instr(enc_reg(OP_SHL, 5'd1, 5'd13, 5'd0), 32'h0000_102c);
        issue_instr(enc_imm(OP_ADDI, 5'd0, 5'd14, 16'h4000), 32'h0000_1030);
        issue_instr(enc_imm(OP_LD_RI, 5'd14, 5'd15, 16'h0000), 32'h0000_1034);
        issue_instr(enc_off(OP_ST, 5'd3, 5'd1, 16'h0000), 32'h0000_1038);
        issue_instr(enc_off(OP_ST, 5'd0, 5'd5, 16'h3ffc), 32'h0000_103c);
        issue_instr(enc_off(OP_BEQ, 5'd1, 5'd1, 16'h8000), 32'h0000_0000);
        issue_instr(enc_off(OP_BNE_L, 5'd0, 5'd31, 16'h7fff), 32'hffff_fff0);
        issue_instr(enc_off(OP_BEQ_L, 5'd0, 5'd0, 16'h0000), 32'h0000_2000);
        issue_instr(enc_long(OP_BR, 26'h1ff_ffff), 32'h0000_0000);
        issue_instr(enc_long(OP_BCC, 26'h200_0000), 32'h0000_0000);
        issue_instr(enc_imm(OP_HALT, 5'd0, 5'd0, 16'h0000), 32'h0000_3000);
        issue_instr(enc_imm(OP_UNUSED, 5'd31, 5'd31, 16'hffff), 32'hffff_ffff);
    endtask

    // Result side: check every delivered result, stall at random, hold off once for long
    initial begin
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = idle_cycles();
            end
        end
    end

    // Request side and end of run
    initial begin
        int r;
        sb           = new();
        n_sent       = 0;
        hold_off_req = 1'b0;
        calm         = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        while (n_sent < NUM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) send_preload(12'($urandom()), $urandom());
            else if (r < 70) run_sequence();
            else issue_instr(random_instr(), $urandom());
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_500_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: risc_subset_execute_unit.f
design/rse_pkg.sv
design/rse_regfile.sv
design/rse_dmem.sv
design/rse_exec.sv
design/risc_subset_execute_unit.sv
design/rse_checker.sv
sim/risc_subset_execute_unit_tb.sv
